>>> sv/ks01_pkg.sv
// ----------------------------------------------------------------------------
// ks01_pkg
// Shared constants, widths and controller/datapath types for the 0/1 knapsack
// best-value engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ks01_pkg;

    // Largest capacity that the row of best totals covers.
    localparam int MAX_CAPACITY = 1023;
    localparam int ROW_DEPTH    = MAX_CAPACITY + 1;
    localparam int ADDR_W       = $clog2(ROW_DEPTH);

    // Field widths of the item, the register and the result.
    localparam int WEIGHT_W = 10;
    localparam int VALUE_W  = 16;
    localparam int CAP_W    = 10;
    localparam int BEST_W   = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture a new item and start the address counter
        logic step;     // issue the reads for the current capacity entry
        logic finish;   // the pass is over; the last write lands this cycle
        logic publish;  // move the captured total into the output register
    } ks01_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_done;  // the address counter stands at entry zero
        logic last_item;   // the item in work closes its set
    } ks01_status_t;

endpackage : ks01_pkg

`default_nettype wire

>>> sv/ks01_ram.sv
// ----------------------------------------------------------------------------
// ks01_ram
// Generic RAM with one write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ks01_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic      [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic      [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and both registered read ports.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule : ks01_ram

`default_nettype wire

>>> sv/ks01_dp.sv
// ----------------------------------------------------------------------------
// ks01_dp
// Datapath: item registers, capacity counter, row memory, the saturating
// add-and-compare update, and capture of the reported total.
// ----------------------------------------------------------------------------
`default_nettype none

module ks01_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ks01_pkg::ks01_cmd_t             cmd,
    output ks01_pkg::ks01_status_t               status,
    input  wire logic                            cfg_we,
    input  wire logic [ks01_pkg::CAP_W-1:0]      cfg_capacity,
    input  wire logic [ks01_pkg::WEIGHT_W-1:0]   item_weight,
    input  wire logic [ks01_pkg::VALUE_W-1:0]    item_value,
    input  wire logic                            last_item,
    output logic      [ks01_pkg::BEST_W-1:0]     best_value
);

    import ks01_pkg::*;

    // Control state.
    logic [CAP_W-1:0]    cap_reg;
    logic                fresh_reg;
    logic                pass_fresh_reg;
    logic                vld_d_reg;

    // Payload registers.
    logic [WEIGHT_W-1:0] w_reg;
    logic [VALUE_W-1:0]  v_reg;
    logic                last_reg;
    logic [ADDR_W-1:0]   cnt_reg;
    logic [ADDR_W-1:0]   c_d_reg;
    logic                take_d_reg;
    logic [BEST_W-1:0]   res_reg;
    logic [BEST_W-1:0]   best_value_reg;

    // Memory ports and update logic.
    logic [ADDR_W-1:0]   rd_addr_b;
    logic [BEST_W-1:0]   rd_data_a;
    logic [BEST_W-1:0]   rd_data_b;
    logic [BEST_W-1:0]   old_val;
    logic [BEST_W-1:0]   prev_val;
    logic [BEST_W:0]     sum_wide;
    logic [BEST_W-1:0]   cand_val;
    logic [BEST_W-1:0]   new_val;
    logic [ADDR_W-1:0]   cap_eff;
    logic                item_takes;

    // The register never exceeds the row, but a larger limit reads the top entry.
    assign cap_eff = (cap_reg > CAP_W'(MAX_CAPACITY)) ? ADDR_W'(MAX_CAPACITY)
                                                      : ADDR_W'(cap_reg);

    // The entry one item-weight lower still holds its value from before this item.
    assign rd_addr_b  = cnt_reg - ADDR_W'(w_reg);
    assign item_takes = (w_reg != '0) && ({1'b0, cnt_reg} >= (ADDR_W+1)'(w_reg));

    ks01_ram #(
        .WIDTH (BEST_W),
        .DEPTH (ROW_DEPTH)
    ) u_row (
        .clk       (clk),
        .wr_en     (vld_d_reg),
        .wr_addr   (c_d_reg),
        .wr_data   (new_val),
        .rd_addr_a (cnt_reg),
        .rd_data_a (rd_data_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_b (rd_data_b)
    );

    // The first pass after a result or reset sees an all-zero row.
    assign old_val  = pass_fresh_reg ? '0 : rd_data_a;
    assign prev_val = pass_fresh_reg ? '0 : rd_data_b;

    // Saturating candidate total and the max against the current entry.
    assign sum_wide = {1'b0, prev_val} + (BEST_W+1)'(v_reg);
    assign cand_val = sum_wide[BEST_W] ? '1 : sum_wide[BEST_W-1:0];

    always_comb
    begin
        if (c_d_reg == '0)
        begin
            new_val = '0;
        end
        else if (take_d_reg && (cand_val > old_val))
        begin
            new_val = cand_val;
        end
        else
        begin
            new_val = old_val;
        end
    end

    // Control registers: capacity, freshness of the row, write strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg        <= '0;
            fresh_reg      <= 1'b1;
            pass_fresh_reg <= 1'b1;
            vld_d_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_capacity;
            end
            if (cmd.load)
            begin
                pass_fresh_reg <= fresh_reg;
                fresh_reg      <= 1'b0;
            end
            else if (cmd.finish && last_reg)
            begin
                fresh_reg <= 1'b1;
            end
            vld_d_reg <= cmd.step;
        end
    end

    // Item capture, address counter, pipeline and result registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            w_reg    <= item_weight;
            v_reg    <= item_value;
            last_reg <= last_item;
            cnt_reg  <= ADDR_W'(MAX_CAPACITY);
        end
        else if (cmd.step)
        begin
            cnt_reg <= cnt_reg - ADDR_W'(1);
        end
        c_d_reg    <= cnt_reg;
        take_d_reg <= item_takes;
        if (vld_d_reg && (c_d_reg == cap_eff))
        begin
            res_reg <= new_val;
        end
        if (cmd.publish)
        begin
            best_value_reg <= res_reg;
        end
    end

    assign status.sweep_done = (cnt_reg == '0);
    assign status.last_item  = last_reg;
    assign best_value        = best_value_reg;

    // Entry zero is always written as zero.
    a_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_d_reg && (c_d_reg == '0)) |-> (new_val == '0))
        else $error("entry zero written with a nonzero total");

    // On a fresh row an entry that the item cannot reach is written as zero.
    a_fresh_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_d_reg && pass_fresh_reg && !take_d_reg) |-> (new_val == '0))
        else $error("stale row contents survived a clear");

endmodule : ks01_dp

`default_nettype wire

>>> sv/ks01_ctrl.sv
// ----------------------------------------------------------------------------
// ks01_ctrl
// Controller: accepts an item, sweeps the row from the top capacity down,
// drains the last write and hands each set's result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ks01_ctrl (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output ks01_pkg::ks01_cmd_t          cmd,
    input  wire ks01_pkg::ks01_status_t  status
);

    import ks01_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_PUBLISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // The output register can take a new total when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // Next state and commands.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP:
            begin
                cmd.step = 1'b1;
                if (status.sweep_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                cmd.finish = 1'b1;
                state_next = status.last_item ? ST_PUBLISH : ST_IDLE;
            end
            ST_PUBLISH:
            begin
                if (out_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // An accepted item always starts a sweep.
    a_accept_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_SWEEP))
        else $error("accepted item did not start a sweep");

    // The sweep runs until the counter reaches entry zero.
    a_sweep_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SWEEP) && !status.sweep_done) |=> (state_reg == ST_SWEEP))
        else $error("sweep ended early");

    // A publish always presents a result in the next cycle.
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid_reg)
        else $error("published total not presented");

    // A result is never published over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |-> (!out_valid_reg || out_ready))
        else $error("result overwritten before transfer");

endmodule : ks01_ctrl

`default_nettype wire

>>> sv/knapsack_01_max_value.sv
// A last item goes through sweep, drain and publish before its result is presented.
// Items do not overlap: each takes the whole sweep of the row, then a drain state
// for the last row write and the idle state that takes the next transfer.
// A waiting result blocks no item; only the next publish waits for it to be taken.
// Reset: asynchronous, active low; clears control state and the capacity register,
// and the row reads as all zeros with no clearing pass (the first pass masks it).
// ----------------------------------------------------------------------------
// knapsack_01_max_value
// 0/1 knapsack engine: keeps one row of best totals by capacity and reports
// the best total for the configured capacity at the end of each item set.
// ----------------------------------------------------------------------------
`default_nettype none

module knapsack_01_max_value (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [ks01_pkg::CAP_W-1:0]      capacity,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic [ks01_pkg::WEIGHT_W-1:0]   item_weight,
    input  wire logic [ks01_pkg::VALUE_W-1:0]    item_value,
    input  wire logic                            last_item,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [ks01_pkg::BEST_W-1:0]     best_value
);

    import ks01_pkg::*;

    ks01_cmd_t    cmd;
    ks01_status_t status;

    // The capacity register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    ks01_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    ks01_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_capacity (capacity),
        .item_weight  (item_weight),
        .item_value   (item_value),
        .last_item    (last_item),
        .best_value   (best_value)
    );

endmodule : knapsack_01_max_value

`default_nettype wire
